[hw/rtl/bmt_pkg.sv]
// ----------------------------------------------------------------------------
// bmt_pkg
// Shared widths, operation codes, register map and controller/datapath
// command and status types for the block membership table.
// ----------------------------------------------------------------------------
package bmt_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int OP_W      = 3;
    localparam int BLOCK_W   = 64;
    localparam int CLUS_W    = 32;
    localparam int BPC_W     = 12;
    localparam int CNT_OUT_W = 7;
    localparam int LEN_W     = CLUS_W + BPC_W;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [OP_W-1:0] OP_UPTODATE  = 3'd0;
    localparam logic [OP_W-1:0] OP_READAHEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd3;
    localparam logic [OP_W-1:0] OP_RANGE     = 3'd4;
    localparam logic [OP_W-1:0] OP_PURGE     = 3'd5;

    // word index of the blocks-per-cluster register
    localparam logic REG_BPC = 1'b0;
    localparam logic [BPC_W-1:0] BPC_RESET = 12'd1;

    typedef struct packed {
        logic load;    // latch the incoming transaction
        logic prep;    // range length, clear scan counters
        logic scan;    // issue table reads
        logic finish;  // commit count, load result register
    } t_cmd;

    typedef struct packed {
        logic scans;      // operation walks the table
        logic scan_done;  // all live entries compared
        logic rsp_room;   // result register can take a new result
    } t_sts;

endpackage

[hw/rtl/bmt_if.sv]
// ----------------------------------------------------------------------------
// bmt_if
// Request and response channels of the block membership table.
// ----------------------------------------------------------------------------
interface bmt_req_if import bmt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OP_W-1:0]      operation;
    logic [BLOCK_W-1:0]   block;
    logic                 buffer_valid;
    logic                 in_journal;
    logic                 io_pending;
    logic [CLUS_W-1:0]    cluster_count;

    modport source (
        output valid, operation, block, buffer_valid, in_journal, io_pending,
               cluster_count,
        input  ready
    );
    modport sink (
        input  valid, operation, block, buffer_valid, in_journal, io_pending,
               cluster_count,
        output ready
    );
endinterface

interface bmt_rsp_if import bmt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 answer;
    logic                 status;
    logic [CNT_OUT_W-1:0] entries_held;
    logic [CNT_OUT_W-1:0] removed_count;

    modport source (
        output valid, answer, status, entries_held, removed_count,
        input  ready
    );
    modport sink (
        input  valid, answer, status, entries_held, removed_count,
        output ready
    );
endinterface

[hw/rtl/bmt_ram.sv]
// ----------------------------------------------------------------------------
// bmt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module bmt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/bmt_ctrl.sv]
// ----------------------------------------------------------------------------
// bmt_ctrl
// Sequencer: accept, prepare, table scan, commit.
// ----------------------------------------------------------------------------
module bmt_ctrl import bmt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = i_sts.scans ? S_SCAN : S_FIN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.rsp_room) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[hw/rtl/bmt_dp.sv]
// ----------------------------------------------------------------------------
// bmt_dp
// Datapath: transaction latch, range length, scan/compaction over the
// block RAM, entry count and result register.
// ----------------------------------------------------------------------------
module bmt_dp import bmt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_sts                 o_sts,
    input  logic [OP_W-1:0]      i_operation,
    input  logic [BLOCK_W-1:0]   i_block,
    input  logic                 i_buffer_valid,
    input  logic                 i_in_journal,
    input  logic                 i_io_pending,
    input  logic [CLUS_W-1:0]    i_cluster_count,
    input  logic [BPC_W-1:0]     i_bpc,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_answer,
    output logic                 o_status,
    output logic [CNT_OUT_W-1:0] o_entries_held,
    output logic [CNT_OUT_W-1:0] o_removed_count
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [OP_W-1:0]    r_op;
    logic [BLOCK_W-1:0] r_blk;
    logic               r_valid_b;
    logic               r_journal;
    logic               r_pending;
    logic [CLUS_W-1:0]  r_clus;
    logic [LEN_W-1:0]   r_len;

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_wr;
    logic [CNT_W-1:0]   r_gone;
    logic               r_pend;
    logic               r_found;

    logic                 r_out_valid;
    logic                 r_answer;
    logic                 r_status;
    logic [CNT_OUT_W-1:0] r_held;
    logic [CNT_OUT_W-1:0] r_removed;

    logic                 n_answer;
    logic                 n_status;
    logic [CNT_W-1:0]     n_count;
    logic [CNT_W-1:0]     n_removed;

    logic [BLOCK_W-1:0] ram_q;
    logic [BLOCK_W-1:0] diff;
    logic               is_rm;
    logic               hit;
    logic               match;
    logic               issue;
    logic               keep_wr;
    logic               ins_wr;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [BLOCK_W-1:0] ram_wdata;

    // compare stage, one stored entry per cycle
    assign diff    = ram_q - r_blk;
    assign is_rm   = (r_op == OP_REMOVE) || (r_op == OP_RANGE);
    assign hit     = diff < BLOCK_W'(r_len);
    assign match   = ram_q == r_blk;
    assign issue   = i_cmd.scan && (r_rd < r_count);
    assign keep_wr = r_pend && is_rm && !hit;
    assign ins_wr  = i_cmd.finish && (r_op == OP_INSERT) && !r_found && (r_count < CAP_CNT);

    assign ram_we    = keep_wr || ins_wr;
    assign ram_waddr = ins_wr ? r_count[AW-1:0] : r_wr[AW-1:0];
    assign ram_wdata = ins_wr ? r_blk : ram_q;

    bmt_ram #(
        .WIDTH (BLOCK_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd[AW-1:0]),
        .o_rdata (ram_q)
    );

    assign o_sts.scans     = r_op <= OP_RANGE;
    assign o_sts.scan_done = (r_rd >= r_count) && !r_pend;
    assign o_sts.rsp_room  = !r_out_valid || i_ready;

    // commit values
    always_comb begin
        n_answer  = 1'b0;
        n_status  = 1'b0;
        n_count   = r_count;
        n_removed = '0;
        unique case (r_op) inside
            OP_UPTODATE: begin
                n_answer = r_valid_b && (r_journal || r_found);
            end
            OP_READAHEAD: begin
                n_answer = r_pending && r_found;
            end
            OP_INSERT: begin
                if (!r_found) begin
                    if (r_count < CAP_CNT) begin
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_status = 1'b1;
                    end
                end
            end
            OP_REMOVE, OP_RANGE: begin
                n_count   = r_wr;
                n_removed = r_gone;
            end
            OP_PURGE: begin
                n_removed = r_count;
                n_count   = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // transaction latch, range length, scan counters and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_blk     <= i_block;
            r_valid_b <= i_buffer_valid;
            r_journal <= i_in_journal;
            r_pending <= i_io_pending;
            r_clus    <= i_cluster_count;
        end
        if (i_cmd.prep) begin
            r_len   <= (r_op == OP_REMOVE) ? LEN_W'(1)
                                           : LEN_W'(r_clus) * LEN_W'(i_bpc);
            r_rd    <= '0;
            r_wr    <= '0;
            r_gone  <= '0;
            r_found <= 1'b0;
        end else begin
            if (issue) begin
                r_rd <= r_rd + CNT_W'(1);
            end
            if (r_pend) begin
                if (match) begin
                    r_found <= 1'b1;
                end
                if (is_rm) begin
                    if (hit) begin
                        r_gone <= r_gone + CNT_W'(1);
                    end else begin
                        r_wr <= r_wr + CNT_W'(1);
                    end
                end
            end
        end
        if (i_cmd.finish) begin
            r_answer  <= n_answer;
            r_status  <= n_status;
            r_held    <= CNT_OUT_W'(n_count);
            r_removed <= CNT_OUT_W'(n_removed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pend <= issue;
            if (i_cmd.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_answer        = r_answer;
    assign o_status        = r_status;
    assign o_entries_held  = r_held;
    assign o_removed_count = r_removed;

endmodule

[hw/rtl/block_membership_table.sv]
// Sequence: accept, prepare, walk of the live entries by the single RAM read port
//   (one entry per cycle; queries, insert, remove and range remove only), commit.
//   Purge and unused codes skip the walk. A result still waiting downstream stalls
//   commit. A new transaction is accepted only after the previous one commits.
// Reset: synchronous, active low; empties the set, blocks_per_cluster = 1.
// ----------------------------------------------------------------------------
// block_membership_table
// Bounded set of 64-bit block numbers held compacted in a RAM, with
// membership queries, insert, remove, range remove and purge.
// ----------------------------------------------------------------------------
module block_membership_table import bmt_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bmt_req_if.sink           i_req,
    bmt_rsp_if.source         o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Configuration: one register, blocks per cluster, at word 0.
    // Byte lanes within the word are ignored; other words are ignored.
    // ------------------------------------------------------------------
    logic [BPC_W-1:0] r_bpc;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpc <= BPC_RESET;
        end else if (cfg_wr && (paddr[2] == REG_BPC)) begin
            r_bpc <= pwdata[BPC_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BPC) ? APB_DW'(r_bpc) : '0;

    // ------------------------------------------------------------------
    // Controller and datapath. The controller accepts a transaction only
    // when idle; the result register lets it do so while the previous
    // result is still waiting downstream. The block RAM is not cleared;
    // only live entries are ever read.
    // ------------------------------------------------------------------
    t_cmd cmd;
    t_sts sts;

    bmt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bmt_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_operation     (i_req.operation),
        .i_block         (i_req.block),
        .i_buffer_valid  (i_req.buffer_valid),
        .i_in_journal    (i_req.in_journal),
        .i_io_pending    (i_req.io_pending),
        .i_cluster_count (i_req.cluster_count),
        .i_bpc           (r_bpc),
        .o_valid         (o_rsp.valid),
        .i_ready         (o_rsp.ready),
        .o_answer        (o_rsp.answer),
        .o_status        (o_rsp.status),
        .o_entries_held  (o_rsp.entries_held),
        .o_removed_count (o_rsp.removed_count)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a result is never committed over one still waiting
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> sts.rsp_room)
        else $error("result committed while result register busy");

    // a dropped insert only ever reports a full table
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status) |-> (o_rsp.entries_held == CNT_OUT_W'(CAPACITY)))
        else $error("insert flagged as dropped with table not full");

    // one transaction in flight: no acceptance in the cycle after one
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("second transaction accepted while busy");

endmodule
